### sv/tofm_pkg.sv
// Shared constants, register codes and the quarter-wave sine generator for the FM oscillator.
package tofm_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int INC_W       = 32;
    localparam int DEPTH_W     = 20;
    localparam int MAG_W       = 15;
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = MAG_W + DEPTH_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_CARRIER_INC = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOD_INC     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOD_DEPTH   = 2'd2;

    localparam logic [INC_W-1:0]   RST_CARRIER_INC = 32'd39370533;
    localparam logic [INC_W-1:0]   RST_MOD_INC     = 32'd19685266;
    localparam logic [DEPTH_W-1:0] RST_MOD_DEPTH   = 20'd1043;

    localparam logic [63:0] COEF1 = 64'd1686629713;
    localparam logic [63:0] COEF3 = 64'd693598670;
    localparam logic [63:0] COEF5 = 64'd85569305;
    localparam logic [63:0] COEF7 = 64'd5026995;
    localparam logic [63:0] COEF9 = 64'd172273;
    localparam logic [63:0] Q30_HALF = 64'd1 << 29;
    localparam logic [63:0] Q15_MAX  = 64'd32767;

    // Quarter-wave sine magnitude in Q15 for a position t in Q30 (0..1).
    // Used only with constant arguments, so it folds into a table at elaboration.
    function automatic logic [MAG_W-1:0] quarter_q15(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] p;
        logic [63:0] y;
        logic [63:0] q;
        t2 = (t * t) >> 30;
        p  = COEF9;
        p  = COEF7 - ((t2 * p) >> 30);
        p  = COEF5 - ((t2 * p) >> 30);
        p  = COEF3 - ((t2 * p) >> 30);
        p  = COEF1 - ((t2 * p) >> 30);
        y  = (t * p) >> 30;
        q  = (y * Q15_MAX + Q30_HALF) >> 30;
        if (q > Q15_MAX) begin
            q = Q15_MAX;
        end
        return q[MAG_W-1:0];
    endfunction

endpackage

### sv/two_operator_fm_oscillator_unit.sv
// Two-operator FM oscillator: five-register pipeline from tick beat to sample beat.
// Throughput: one tick beat per cycle while the output is not stalled; after the input
// register come modulator lookup, depth multiply, offset and phase add, and carrier
// lookup into the output register.
// Reset (synchronous, active low) clears both phases and the pipeline valids and loads
// the default increments and modulation depth.
module two_operator_fm_oscillator_unit #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_WIDTH     = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_restart,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [tofm_pkg::SAMPLE_W-1:0] o_sample,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tofm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [tofm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tofm_pkg::*;

    localparam int TB = SINE_TABLE_BITS;
    localparam int PW = PHASE_WIDTH;
    localparam int QUARTER = 1 << (TB - 2);
    localparam int POS_SHIFT = 30 - (TB - 2);

    // Configuration registers
    logic [INC_W-1:0]   r_carrier_inc;
    logic [INC_W-1:0]   r_mod_inc;
    logic [DEPTH_W-1:0] r_mod_depth;

    // Phase accumulators
    logic [PW-1:0] r_cph;
    logic [PW-1:0] r_mph;
    logic [PW-1:0] n_cph_cur;
    logic [PW-1:0] n_mph_cur;

    // Pipeline stages
    logic          r_v1, r_v2, r_v3, r_v4, r_v5;
    logic          en1, en2, en3, en4, en5;
    logic          accept;
    logic [PW-1:0] r_cph1, r_cph2, r_cph3;
    logic [TB-1:0] r_midx1;
    logic [MAG_W-1:0] r_mmag2;
    logic          r_msgn2, r_msgn3;
    logic [PROD_W-1:0] r_prod3;
    logic [TB-1:0] r_cidx4;
    logic signed [SAMPLE_W-1:0] r_sample;

    logic [MAG_W-1:0] w_qtab [0:QUARTER];
    logic [PW-1:0]    w_off_mag;
    logic [PW-1:0]    w_off;
    logic [PW-1:0]    w_phase;
    logic [MAG_W-1:0] w_cmag;
    logic [MAG_W-1:0] w_mmag;

    // Quarter-wave table, one entry past the quarter so mirrored quadrants hit the peak.
    for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_qtab
        assign w_qtab[gi] = quarter_q15(64'(gi) << POS_SHIFT);
    end

    // Position within the quarter wave, mirrored in the odd quadrants.
    function automatic logic [TB-2:0] f_pos(input logic [TB-1:0] idx);
        logic [TB-2:0] r;
        r = {1'b0, idx[TB-3:0]};
        return idx[TB-2] ? ((TB-1)'(QUARTER) - r) : r;
    endfunction

    assign w_mmag = w_qtab[f_pos(r_midx1)];
    assign w_cmag = w_qtab[f_pos(r_cidx4)];

    // Each stage loads when it is empty or the stage after it loads.
    assign en5    = !r_v5 || !i_stall;
    assign en4    = !r_v4 || en5;
    assign en3    = !r_v3 || en4;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign o_stall = !en1;
    assign accept = i_valid && en1;

    assign n_cph_cur = i_restart ? '0 : r_cph;
    assign n_mph_cur = i_restart ? '0 : r_mph;

    // Scale the product to the phase width.
    if (PW >= 31) begin : g_off_shl
        logic [PROD_W+PW-1:0] w_ext;
        assign w_ext     = (PROD_W + PW)'(r_prod3) << (PW - 31);
        assign w_off_mag = w_ext[PW-1:0];
    end else begin : g_off_shr
        localparam int SH = 31 - PW;
        logic [PROD_W:0] w_sum;
        assign w_sum     = {1'b0, r_prod3} + ((PROD_W + 1)'(1) << (SH - 1));
        assign w_off_mag = PW'(w_sum >> SH);
    end

    assign w_off   = r_msgn3 ? (PW'(0) - w_off_mag) : w_off_mag;
    assign w_phase = r_cph3 + w_off;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_inc <= RST_CARRIER_INC;
            r_mod_inc     <= RST_MOD_INC;
            r_mod_depth   <= RST_MOD_DEPTH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CARRIER_INC: r_carrier_inc <= i_cfg_data;
                CFG_MOD_INC:     r_mod_inc     <= i_cfg_data;
                CFG_MOD_DEPTH:   r_mod_depth   <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cph <= '0;
            r_mph <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
        end else begin
            if (accept) begin
                r_cph <= n_cph_cur + PW'(r_carrier_inc);
                r_mph <= n_mph_cur + PW'(r_mod_inc);
            end
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_cph1  <= n_cph_cur;
            r_midx1 <= n_mph_cur[PW-1 -: TB];
        end
        if (en2) begin
            r_cph2  <= r_cph1;
            r_mmag2 <= w_mmag;
            r_msgn2 <= r_midx1[TB-1];
        end
        if (en3) begin
            r_cph3  <= r_cph2;
            r_prod3 <= PROD_W'(r_mmag2) * PROD_W'(r_mod_depth);
            r_msgn3 <= r_msgn2;
        end
        if (en4) begin
            r_cidx4 <= w_phase[PW-1 -: TB];
        end
        if (en5) begin
            r_sample <= r_cidx4[TB-1] ? -$signed({1'b0, w_cmag}) : $signed({1'b0, w_cmag});
        end
    end

    assign o_valid  = r_v5;
    assign o_sample = r_sample;

    // A restart beat leaves the carrier phase at exactly one increment.
    a_restart_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_restart) |=> (r_cph == $past(PW'(r_carrier_inc))))
        else $error("carrier phase wrong after restart");

    // The input side only stalls when every stage holds a beat.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5))
        else $error("input stalled with a bubble in the pipeline");

    // The sine magnitude never exceeds full scale, so the most negative code never appears.
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample != {1'b1, {(SAMPLE_W-1){1'b0}}}))
        else $error("sample out of range");

endmodule
